// ----- sv/cqe_pkg.sv -----
// Package for the completion queue engine: sizes, codes and word types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cqe_pkg;
  localparam int Depth = 256;
  localparam int MaxPoll = 64;
  localparam int PtrW = $clog2(Depth);
  localparam int OccW = $clog2(Depth + 1);

  localparam logic [2:0] FuncInsert = 3'd0;
  localparam logic [2:0] FuncPoll = 3'd1;
  localparam logic [2:0] FuncArm = 3'd2;
  localparam logic [2:0] FuncRemove = 3'd3;
  localparam logic [2:0] FuncForce = 3'd4;

  localparam logic [1:0] CodeOk = 2'd0;
  localparam logic [1:0] CodeErr = 2'd1;
  localparam logic [1:0] CodeOvf = 2'd2;

  localparam logic [1:0] EvNone = 2'd0;
  localparam logic [1:0] EvComp = 2'd1;
  localparam logic [1:0] EvErr = 2'd2;

  localparam logic [1:0] ModeNone = 2'd0;
  localparam logic [1:0] ModeSol = 2'd1;
  localparam logic [1:0] ModeNext = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] wr_id_in;
    logic [7:0]  wc_status_in;
    logic [7:0]  opcode_in;
    logic [23:0] qp_num_in;
    logic [31:0] byte_len_in;
    logic [31:0] imm_in;
    logic [7:0]  wc_flags_in;
    logic        solicited;
    logic [6:0]  poll_count;
    logic [2:0]  arm_flags;
  } cqe_in_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [63:0] wr_id_out;
    logic [7:0]  wc_status_out;
    logic [7:0]  opcode_out;
    logic [23:0] qp_num_out;
    logic [31:0] byte_len_out;
    logic [31:0] imm_out;
    logic [7:0]  wc_flags_out;
    logic [1:0]  event_out;
    logic        missed_out;
    logic [8:0]  count_out;
    logic        last;
  } cqe_out_t;

  // One stored completion.
  typedef struct packed {
    logic [63:0] wr_id;
    logic [7:0]  status;
    logic [7:0]  opcode;
    logic [23:0] qp;
    logic [31:0] len;
    logic [31:0] imm;
    logic [7:0]  flags;
  } cqe_entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic            mem_we;
    logic [PtrW-1:0] wr_addr;
    logic            wr_from_in;
    logic            rd_en;
    logic [PtrW-1:0] rd_addr;
  } cqe_cmd_t;
endpackage

// ----- sv/cqe_datapath.sv -----
// Datapath of the completion queue engine: the entry memory with its
// registered read port. Depends on cqe_pkg.
`timescale 1ns / 1ps
module cqe_datapath (
  input  logic               clk_i,
  input  cqe_pkg::cqe_cmd_t  cmd_i,
  input  cqe_pkg::cqe_in_t   in_i,
  output cqe_pkg::cqe_entry_t rd_data_o
);
  import cqe_pkg::*;

  cqe_entry_t mem_q [Depth];
  cqe_entry_t wr_data;

  always_comb begin
    if (cmd_i.wr_from_in) begin
      wr_data = '{wr_id: in_i.wr_id_in, status: in_i.wc_status_in,
                  opcode: in_i.opcode_in, qp: in_i.qp_num_in,
                  len: in_i.byte_len_in, imm: in_i.imm_in,
                  flags: in_i.wc_flags_in};
    end else begin
      // Compaction copies the word just read down to its new slot.
      wr_data = rd_data_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_o <= mem_q[cmd_i.rd_addr];
    end
  end
endmodule

// ----- sv/cqe_ctrl.sv -----
// Controller of the completion queue engine: queue pointers, error and
// notify state, and the sequencer for poll and remove. Depends on cqe_pkg.
`timescale 1ns / 1ps
module cqe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  cqe_pkg::cqe_in_t    in_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [8:0]          cfg_data_i,
  output cqe_pkg::cqe_cmd_t   cmd_o,
  input  cqe_pkg::cqe_entry_t rd_data_i,
  output logic                res_valid_o,
  output cqe_pkg::cqe_out_t   res_o
);
  import cqe_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPoll = 3'd1;
  localparam logic [2:0] StRem = 3'd2;
  localparam logic [2:0] StRemDone = 3'd3;

  logic [2:0] state_q, state_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [OccW-1:0] occ_q, occ_d;
  logic err_q, err_d;
  logic [1:0] mode_q, mode_d;
  logic notified_q, notified_d;
  logic [8:0] cap_q;
  cqe_in_t in_q, in_d;
  logic [6:0] n_q, n_d;        // entries left to pop
  logic [6:0] k_q, k_d;        // entries popped
  logic [OccW-1:0] i_q, i_d;   // read index during remove
  logic [OccW-1:0] w_q, w_d;   // write index during remove
  logic rv_q, rv_d;            // a read word is waiting to be judged
  logic res_v_d;
  cqe_out_t res_d;
  logic [OccW-1:0] cap_eff;
  logic [6:0] n_lim;
  logic accept;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign cap_eff = (cap_q > 9'(Depth)) ? OccW'(Depth) : OccW'(cap_q);

  always_comb begin
    n_lim = (in_i.poll_count > 7'(MaxPoll)) ? 7'(MaxPoll) : in_i.poll_count;
    if (OccW'(n_lim) > occ_q) n_lim = 7'(occ_q);
  end

  always_comb begin
    state_d = state_q; head_d = head_q; occ_d = occ_q; err_d = err_q;
    mode_d = mode_q; notified_d = notified_q; in_d = in_q;
    n_d = n_q; k_d = k_q; i_d = i_q; w_d = w_q; rv_d = 1'b0;
    res_v_d = 1'b0; res_d = '0; res_d.last = 1'b1;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          in_d = in_i;
          case (in_i.func)
            FuncInsert: begin
              res_v_d = 1'b1;
              if (err_q) begin
                res_d.result_code = CodeErr;
              end else if (occ_q >= cap_eff) begin
                err_d = 1'b1;
                res_d.result_code = CodeOvf;
                res_d.event_out = EvErr;
              end else begin
                cmd_o.mem_we = 1'b1;
                cmd_o.wr_from_in = 1'b1;
                cmd_o.wr_addr = head_q + PtrW'(occ_q);
                occ_d = occ_q + OccW'(1);
                if ((mode_q == ModeNext || (mode_q == ModeSol && in_i.solicited))
                    && !notified_q) begin
                  notified_d = 1'b1;
                  res_d.event_out = EvComp;
                end
              end
            end
            FuncPoll: begin
              if (err_q) begin
                res_v_d = 1'b1;
                res_d.result_code = CodeErr;
              end else if (n_lim == '0) begin
                res_v_d = 1'b1;
              end else begin
                cmd_o.rd_en = 1'b1;
                cmd_o.rd_addr = head_q;
                n_d = n_lim; k_d = '0;
                state_d = StPoll;
              end
            end
            FuncArm: begin
              res_v_d = 1'b1;
              if (err_q) begin
                res_d.result_code = CodeErr;
              end else begin
                if (in_i.arm_flags[0]) mode_d = ModeSol;
                else if (in_i.arm_flags[1]) mode_d = ModeNext;
                res_d.missed_out = in_i.arm_flags[2] && (occ_q != '0);
                notified_d = 1'b0;
              end
            end
            FuncRemove: begin
              i_d = '0; w_d = '0;
              state_d = StRem;
            end
            FuncForce: begin
              res_v_d = 1'b1;
              err_d = 1'b1;
              res_d.event_out = EvErr;
            end
            default: res_v_d = 1'b1;
          endcase
        end
      end
      StPoll: begin
        // Read word for the head is ready; emit it and fetch the next unless it is the last.
        res_v_d = 1'b1;
        res_d.wr_id_out = rd_data_i.wr_id;
        res_d.wc_status_out = rd_data_i.status;
        res_d.opcode_out = rd_data_i.opcode;
        res_d.qp_num_out = rd_data_i.qp;
        res_d.byte_len_out = rd_data_i.len;
        res_d.imm_out = rd_data_i.imm;
        res_d.wc_flags_out = rd_data_i.flags;
        res_d.count_out = 9'(k_q) + 9'd1;
        res_d.last = (n_q == 7'd1);
        head_d = head_q + PtrW'(1);
        occ_d = occ_q - OccW'(1);
        k_d = k_q + 7'd1;
        n_d = n_q - 7'd1;
        if (n_q == 7'd1) begin
          state_d = StIdle;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = head_q + PtrW'(1);
        end
      end
      StRem: begin
        // Read one entry a cycle; judge the previous read and compact it if its qp differs.
        if (rv_q) begin
          if (rd_data_i.qp != in_q.qp_num_in) begin
            cmd_o.mem_we = 1'b1;
            cmd_o.wr_addr = head_q + PtrW'(w_q);
            w_d = w_q + OccW'(1);
          end
        end
        if (i_q < occ_q) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = head_q + PtrW'(i_q);
          i_d = i_q + OccW'(1);
          rv_d = 1'b1;
        end else begin
          state_d = StRemDone;
        end
      end
      StRemDone: begin
        res_v_d = 1'b1;
        res_d.count_out = 9'(occ_q - w_q);
        occ_d = w_q;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; head_q <= '0; occ_q <= '0; err_q <= 1'b0;
      mode_q <= ModeNone; notified_q <= 1'b1; cap_q <= 9'd256;
      rv_q <= 1'b0; res_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; head_q <= head_d; occ_q <= occ_d; err_q <= err_d;
      mode_q <= mode_d; notified_q <= notified_d; rv_q <= rv_d;
      res_valid_o <= res_v_d;
      if (cfg_valid_i) cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d; n_q <= n_d; k_q <= k_d; i_q <= i_d; w_q <= w_d;
    res_o <= res_d;
  end
endmodule

// ----- sv/completion_queue_engine_unit.sv -----
// Top level of the completion queue engine: controller plus entry datapath.
// Depends on cqe_pkg, cqe_ctrl and cqe_datapath.
//
// channel  | signals                        | handshake
// command  | start_i, busy_o, cmd_i         | taken when start_i && !busy_o
// result   | res_valid_o, res_o             | one-cycle strobe, never stalled
// config   | cfg_valid_i, cfg_ready_o, cfg_data_i | taken when valid && ready
//
// Insert, arm, force error and unknown words finish on acceptance; the result
// appears the cycle after. A poll of n entries reads them one per result through
// the registered memory read port. Remove reads each entry once and compacts the queue.
// Reset leaves the queue empty, ok, unarmed, capacity 256.
`timescale 1ns / 1ps
module completion_queue_engine_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cqe_pkg::cqe_in_t  cmd_i,
  output logic              res_valid_o,
  output cqe_pkg::cqe_out_t res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [8:0]        cfg_data_i
);
  import cqe_pkg::*;

  cqe_cmd_t   dp_cmd;
  cqe_entry_t rd_data;

  cqe_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i(cmd_i),
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .cmd_o(dp_cmd), .rd_data_i(rd_data), .res_valid_o, .res_o
  );

  cqe_datapath u_dp (
    .clk_i, .cmd_i(dp_cmd), .in_i(cmd_i), .rd_data_o(rd_data)
  );
endmodule

// ----- sv/cqe_checker.sv -----
// Port-level checker for the completion queue engine, bound to the top.
// Depends on cqe_pkg and completion_queue_engine_unit.
`timescale 1ns / 1ps
module cqe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input cqe_pkg::cqe_in_t  cmd_i,
  input logic              res_valid_o,
  input cqe_pkg::cqe_out_t res_o
);
  import cqe_pkg::*;

  // Every word other than poll and remove answers on the next cycle.
  a_imm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && cmd_i.func != FuncPoll && cmd_i.func != FuncRemove
    |=> res_valid_o && res_o.last)
    else $error("short word gave no single result");

  a_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy_o)
    else $error("more results promised while idle");

  a_evt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.event_out == EvErr |-> res_o.last && res_o.count_out == '0)
    else $error("error event on a multi-word result");

  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.result_code == CodeOvf |-> res_o.event_out == EvErr)
    else $error("overflow without error event");
endmodule

bind completion_queue_engine_unit cqe_checker u_cqe_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .res_valid_o, .res_o
);
